@@ hdl/rti_pkg.sv @@
// Shared types and constants for the ray/triangle intersection pipeline.
// Used by rti_div and ray_triangle_intersection; depends on nothing.
`default_nettype none

package rti_pkg;

  // Coordinate word and derived internal widths
  localparam int CW        = 32;           // external Q format word
  localparam int EW        = CW + 1;       // edge / offset vector element
  localparam int PW        = 2 * EW;       // one cross-product term
  localparam int XW        = PW + 1;       // cross-product element
  localparam int LW        = EW;           // low slice of a cross element
  localparam int HW        = XW - LW;      // high slice of a cross element
  localparam int DTW       = 104;          // dot products, exact
  localparam int QBITS     = CW - 1;       // quotient bits below saturation
  localparam int FRAC_BITS_DEF = 16;

  // Register map
  localparam int NREG   = 6;
  localparam int ADDR_W = $clog2(NREG * 4);
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_ORIGIN_X = 3'd0;
  localparam reg_idx_t REG_DIR_X    = 3'd3;

  typedef struct packed {
    logic signed [CW-1:0] corner_a_x;
    logic signed [CW-1:0] corner_a_y;
    logic signed [CW-1:0] corner_a_z;
    logic signed [CW-1:0] corner_b_x;
    logic signed [CW-1:0] corner_b_y;
    logic signed [CW-1:0] corner_b_z;
    logic signed [CW-1:0] corner_c_x;
    logic signed [CW-1:0] corner_c_y;
    logic signed [CW-1:0] corner_c_z;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] hit_distance;
    logic signed [CW-1:0] hit_point_x;
    logic signed [CW-1:0] hit_point_y;
    logic signed [CW-1:0] hit_point_z;
  } out_item_t;

  // Sideband that travels with an item through the divider
  typedef struct packed {
    logic valid;
    logic hit;
    logic ovf;
  } div_ctl_t;

endpackage

`default_nettype wire

@@ hdl/rti_div.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on rti_pkg; instantiated by ray_triangle_intersection.
`default_nettype none

module rti_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire rti_pkg::div_ctl_t         ctl_in,
  input  wire logic [rti_pkg::DTW-1:0]   rem_in,
  input  wire logic [rti_pkg::QBITS-1:0] nlow_in,
  input  wire logic [rti_pkg::DTW-1:0]   den_in,
  output      rti_pkg::div_ctl_t         ctl_out,
  output      logic [rti_pkg::QBITS-1:0] quo_out
);
  import rti_pkg::*;

  div_ctl_t           ctl_r  [QBITS];
  logic [DTW-1:0]     rem_r  [QBITS];
  logic [DTW-1:0]     den_r  [QBITS];
  logic [QBITS-1:0]   nlow_r [QBITS];
  logic [QBITS-1:0]   quo_r  [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    div_ctl_t         ctl_p;
    logic [DTW-1:0]   rem_p, den_p, rem_nxt;
    logic [QBITS-1:0] nlow_p, quo_p;
    logic [DTW:0]     trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign ctl_p  = ctl_in;
      assign rem_p  = rem_in;
      assign den_p  = den_in;
      assign nlow_p = nlow_in;
      assign quo_p  = '0;
    end else begin : g_next
      assign ctl_p  = ctl_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign den_p  = den_r[k-1];
      assign nlow_p = nlow_r[k-1];
      assign quo_p  = quo_r[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
      trial   = {rem_p, nlow_p[QBITS-1]};
      ge      = (trial >= {1'b0, den_p});
      rem_nxt = ge ? DTW'(trial - {1'b0, den_p}) : trial[DTW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k].valid <= 1'b0;
      end else if (en) begin
        ctl_r[k] <= ctl_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_p;
        nlow_r[k] <= {nlow_p[QBITS-2:0], 1'b0};
        quo_r[k]  <= {quo_p[QBITS-2:0], ge};
      end
    end
  end

  assign ctl_out = ctl_r[QBITS-1];
  assign quo_out = quo_r[QBITS-1];

endmodule

`default_nettype wire

@@ hdl/ray_triangle_intersection.sv @@
// Top level of the ray/triangle intersection pipeline and its register port.
// Depends on rti_pkg and rti_div.
//
// Usage: write the ray origin and direction over the cfg_ APB port while the
// block is idle (origin_x/y/z at 0x00..0x08, dir_x/y/z at 0x0C..0x14), then
// stream triangles on the in_ channel. Each accepted item yields exactly one
// item on the out_ channel, in order: hit flag, distance t and hit point, or
// all zeros on a miss.
// Structure: 41 register stages; 8 stages of edge, cross and dot-product
// arithmetic, 31 divider stages (one quotient bit each), one hit-point
// multiply stage and the output register.
// Throughput: one item per cycle while not frozen; every stage advances together.
// When out_stall holds a valid result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears the configuration registers and the
// valid flags to zero and empties the pipeline.
`default_nettype none

module ray_triangle_intersection #(
  parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire rti_pkg::in_item_t          in_data,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      rti_pkg::out_item_t         out_data,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [rti_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [rti_pkg::CW-1:0]     cfg_pwdata,
  output      logic [rti_pkg::CW-1:0]     cfg_prdata,
  output      logic                       cfg_pready
);
  import rti_pkg::*;

  localparam int WW = 2 * CW + 1;

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] hi, lo;
    hi = WW'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - WW'(1);
    if (x > hi)      sat_cw = hi[CW-1:0];
    else if (x < lo) sat_cw = lo[CW-1:0];
    else             sat_cw = x[CW-1:0];
  endfunction

  // Configuration registers
  logic signed [CW-1:0] cfg_r [NREG];
  reg_idx_t             cfg_idx;
  logic                 cfg_wr;

  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (32'(cfg_idx) < NREG) ? cfg_r[cfg_idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) cfg_r[i] <= '0;
    end else if (cfg_wr && (32'(cfg_idx) < NREG)) begin
      cfg_r[cfg_idx] <= cfg_pwdata;
    end
  end

  // Global advance: freeze only when a finished item is held
  logic      en;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic [7:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], in_valid};
    end
  end

  // Stage 1: edges, origin offset, direction. Operand order: e1, s, d, e2
  logic signed [CW-1:0] ca [3], cb [3], cc [3];
  assign ca[0] = in_data.corner_a_x;
  assign ca[1] = in_data.corner_a_y;
  assign ca[2] = in_data.corner_a_z;
  assign cb[0] = in_data.corner_b_x;
  assign cb[1] = in_data.corner_b_y;
  assign cb[2] = in_data.corner_b_z;
  assign cc[0] = in_data.corner_c_x;
  assign cc[1] = in_data.corner_c_y;
  assign cc[2] = in_data.corner_c_z;

  logic signed [EW-1:0] ops1_r [4][3], ops2_r [4][3], ops3_r [4][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ops1_r[0][i] <= EW'(cb[i]) - EW'(ca[i]);
        ops1_r[1][i] <= EW'(cfg_r[32'(REG_ORIGIN_X) + i]) - EW'(ca[i]);
        ops1_r[2][i] <= EW'(cfg_r[32'(REG_DIR_X) + i]);
        ops1_r[3][i] <= EW'(cc[i]) - EW'(ca[i]);
      end
      ops2_r <= ops1_r;
      ops3_r <= ops2_r;
    end
  end

  // Stage 2: cross-product terms; h = d x e2, q = s x e1
  logic signed [PW-1:0] pxh_r [6], pxq_r [6];
  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        pxh_r[2*i]   <= ops1_r[2][J] * ops1_r[3][K];
        pxh_r[2*i+1] <= ops1_r[2][K] * ops1_r[3][J];
        pxq_r[2*i]   <= ops1_r[1][J] * ops1_r[0][K];
        pxq_r[2*i+1] <= ops1_r[1][K] * ops1_r[0][J];
      end
    end
  end

  // Stage 3: cross-product elements
  logic signed [XW-1:0] h_r [3], q_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        h_r[i] <= XW'(pxh_r[2*i]) - XW'(pxh_r[2*i+1]);
        q_r[i] <= XW'(pxq_r[2*i]) - XW'(pxq_r[2*i+1]);
      end
    end
  end

  // Stage 4: dot-product partial products, cross element split in two slices
  // dots: den = e1.h, un = s.h, vn = d.q, tn = e2.q
  logic signed [XW-1:0] pph_r [4][3], ppl_r [4][3];
  for (genvar k = 0; k < 4; k++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_el
      logic signed [XW-1:0] x;
      logic signed [HW-1:0] xh;
      logic signed [LW:0]   xl;
      assign x  = (k < 2) ? h_r[i] : q_r[i];
      assign xh = x[XW-1:LW];
      assign xl = $signed({1'b0, x[LW-1:0]});
      always_ff @(posedge clk) begin
        if (en) begin
          pph_r[k][i] <= ops3_r[k][i] * xh;
          ppl_r[k][i] <= ops3_r[k][i] * xl;
        end
      end
    end
  end

  // Stage 5: recombine slices
  logic signed [DTW-1:0] term_r [4][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          term_r[k][i] <= (DTW'(pph_r[k][i]) <<< LW) + DTW'(ppl_r[k][i]);
        end
      end
    end
  end

  // Stage 6: sum the three terms of each dot
  logic signed [DTW-1:0] dot_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        dot_r[k] <= term_r[k][0] + term_r[k][1] + term_r[k][2];
      end
    end
  end

  // Stage 7: make the determinant non-negative
  logic signed [DTW-1:0] nrm_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        nrm_r[k] <= dot_r[0][DTW-1] ? -dot_r[k] : dot_r[k];
      end
    end
  end

  // Stage 8: inside tests and divider setup
  localparam int NW = DTW + CW;
  logic signed [DTW-1:0] den, un, vn, tn, thr;
  logic signed [DTW:0]   uv;
  logic signed [NW-1:0]  tn_w, den_w;
  logic                  miss, ovf_nxt;
  logic [DTW-1:0]        rem_nxt;

  always_comb begin
    den     = nrm_r[0];
    un      = nrm_r[1];
    vn      = nrm_r[2];
    tn      = nrm_r[3];
    thr     = DTW'(1) <<< (2 * FRAC_BITS);
    uv      = (DTW+1)'(un) + (DTW+1)'(vn);
    tn_w    = NW'(tn) <<< FRAC_BITS;
    den_w   = NW'(den);
    miss    = (den < thr) || (un < 0) || (un > den) || (vn < 0)
           || (uv > (DTW+1)'(den)) || (tn_w <= den_w);
    ovf_nxt = (tn_w >= (den_w <<< QBITS));
    rem_nxt = DTW'(tn >>> (QBITS - FRAC_BITS));
  end

  div_ctl_t         s8_ctl_r;
  logic [DTW-1:0]   s8_rem_r, s8_den_r;
  logic [QBITS-1:0] s8_nlow_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_ctl_r  <= '{valid: v_r[6], hit: !miss, ovf: ovf_nxt};
      s8_rem_r  <= rem_nxt;
      s8_den_r  <= den;
      s8_nlow_r <= tn_w[QBITS-1:0];
    end
  end

  // Divider: t = floor(tn * 2^F / den)
  div_ctl_t         div_ctl;
  logic [QBITS-1:0] div_quo;
  div_ctl_t         div_ctl_in;

  always_comb begin
    div_ctl_in       = s8_ctl_r;
    div_ctl_in.valid = v_r[7];
  end

  rti_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (div_ctl_in),
    .rem_in  (s8_rem_r),
    .nlow_in (s8_nlow_r),
    .den_in  (s8_den_r),
    .ctl_out (div_ctl),
    .quo_out (div_quo)
  );

  // Hit-point multiply stage
  logic signed [CW-1:0]   t_nxt, t_r;
  logic signed [2*CW-1:0] prod_r [3];
  logic                   m_v_r, m_hit_r;

  assign t_nxt = div_ctl.ovf ? $signed({1'b0, {QBITS{1'b1}}}) : $signed({1'b0, div_quo});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_hit_r <= div_ctl.hit;
      t_r     <= t_nxt;
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= cfg_r[32'(REG_DIR_X) + i] * t_nxt;
      end
    end
  end

  // Output register: add origin, saturate, zero on miss
  logic signed [CW-1:0] pt [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = sat_cw(WW'(cfg_r[32'(REG_ORIGIN_X) + i]) + (WW'(prod_r[i]) >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.hit          <= m_hit_r;
      out_data_r.hit_distance <= m_hit_r ? t_r : '0;
      out_data_r.hit_point_x  <= m_hit_r ? pt[0] : '0;
      out_data_r.hit_point_y  <= m_hit_r ? pt[1] : '0;
      out_data_r.hit_point_z  <= m_hit_r ? pt[2] : '0;
    end
  end

`ifndef ASSERT_OFF
  // a miss reports all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_distance == '0 &&
      out_data.hit_point_x == '0 && out_data.hit_point_y == '0 &&
      out_data.hit_point_z == '0)
    else $error("miss item carries nonzero fields");

  // a hit lies strictly in front of the origin
  a_hit_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.hit_distance > 0)
    else $error("hit item with non-positive distance");

  // a frozen pipeline keeps its output item
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> out_valid && $stable(out_data))
    else $error("output changed while pipeline frozen");
`endif

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the ray_triangle_intersection pipeline.
// Depends on rti_pkg and the ray_triangle_intersection RTL; needs nothing else.
// Exact wide-integer prediction per triangle, APB ray setup, random flow control.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rti_pkg::*;

  localparam int FRAC   = FRAC_BITS_DEF;
  localparam int ONE    = 1 << FRAC;
  localparam int DRAIN  = 60;
  localparam int WD_MAX = 5000;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [CW-1:0] cfg_pwdata, cfg_prdata;

  // ray registers as the predictor sees them
  logic signed [31:0] ray_org [3];
  logic signed [31:0] ray_dir [3];

  out_item_t pending_hits[$];
  int errors, n_sent, n_checked, n_hits, idle_gap;
  int snd_idle_pct, rcv_stall_pct;
  bit hold_rx;

  ray_triangle_intersection DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // clock
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // exact Moller-Trumbore in 128-bit signed integers
  function automatic out_item_t predict(in_item_t tr);
    logic signed [127:0] a[3], e1[3], e2[3], s[3], d[3], h[3], q[3];
    logic signed [127:0] den, un, vn, tn, quo, p;
    logic signed [31:0] t;
    out_item_t r;
    a[0] = tr.corner_a_x; a[1] = tr.corner_a_y; a[2] = tr.corner_a_z;
    e1[0] = 128'(signed'(tr.corner_b_x)) - a[0];
    e1[1] = 128'(signed'(tr.corner_b_y)) - a[1];
    e1[2] = 128'(signed'(tr.corner_b_z)) - a[2];
    e2[0] = 128'(signed'(tr.corner_c_x)) - a[0];
    e2[1] = 128'(signed'(tr.corner_c_y)) - a[1];
    e2[2] = 128'(signed'(tr.corner_c_z)) - a[2];
    for (int i = 0; i < 3; i++) begin
      s[i] = 128'(signed'(ray_org[i])) - a[i];
      d[i] = ray_dir[i];
    end
    h[0] = d[1] * e2[2] - d[2] * e2[1];
    h[1] = d[2] * e2[0] - d[0] * e2[2];
    h[2] = d[0] * e2[1] - d[1] * e2[0];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    den = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    un  = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    vn  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    tn  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (den < 0) begin
      den = -den; un = -un; vn = -vn; tn = -tn;
    end
    r = '0;
    // parallel, outside u, outside v, behind origin
    if (den < (128'sd1 <<< (2 * FRAC))) return r;
    if (un < 0 || un > den) return r;
    if (vn < 0 || un + vn > den) return r;
    tn = tn <<< FRAC;
    if (tn <= den) return r;
    quo = tn / den;
    t = (quo > 128'(SMAX)) ? SMAX : quo[31:0];
    r.hit = 1'b1;
    r.hit_distance = t;
    for (int i = 0; i < 3; i++) begin
      p = 128'(signed'(ray_org[i])) + ((128'(signed'(ray_dir[i])) * t) >>> FRAC);
      if (p > 128'(SMAX)) p = SMAX;
      if (p < 128'(SMIN)) p = SMIN;
      case (i)
        0: r.hit_point_x = p[31:0];
        1: r.hit_point_y = p[31:0];
        default: r.hit_point_z = p[31:0];
      endcase
    end
    return r;
  endfunction

  // receiver flow control
  always @(negedge clk) begin
    out_stall <= hold_rx || ($urandom_range(99) < rcv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected item %h", $realtime, out_data);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        n_checked++;
        if (want.hit) n_hits++;
        if (want.hit !== out_data.hit)
          $display("%0t: hit exp %0b act %0b", $realtime, want.hit, out_data.hit);
        if (want.hit_distance !== out_data.hit_distance)
          $display("%0t: hit_distance exp %h act %h", $realtime,
                   want.hit_distance, out_data.hit_distance);
        if (want.hit_point_x !== out_data.hit_point_x)
          $display("%0t: hit_point_x exp %h act %h", $realtime,
                   want.hit_point_x, out_data.hit_point_x);
        if (want.hit_point_y !== out_data.hit_point_y)
          $display("%0t: hit_point_y exp %h act %h", $realtime,
                   want.hit_point_y, out_data.hit_point_y);
        if (want.hit_point_z !== out_data.hit_point_z)
          $display("%0t: hit_point_z exp %h act %h", $realtime,
                   want.hit_point_z, out_data.hit_point_z);
        if (want !== out_data) errors++;
      end
    end
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_gap <= 0;
    else idle_gap <= idle_gap + 1;
    if (idle_gap >= WD_MAX) begin
      $display("watchdog: no progress for %0d cycles", WD_MAX);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_tri(in_item_t tr);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tr;
    do @(posedge clk); while (in_stall);
    pending_hits.push_back(predict(tr));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  // full APB rewrite of the ray; block must be idle
  task automatic write_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
    logic signed [31:0] v[6];
    v = '{ox, oy, oz, dx, dy, dz};
    for (int i = 0; i < NREG; i++) begin
      cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
      cfg_paddr <= ADDR_W'(4 * i); cfg_pwdata <= v[i];
      @(negedge clk);
      cfg_penable <= 1'b1;
      @(negedge clk);
    end
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      ray_org[i] = v[i];
      ray_dir[i] = v[3 + i];
    end
    @(negedge clk);
  endtask

  function automatic in_item_t mk_tri(int ax, ay, az, bx, by, bz, cx, cy, cz);
    return '{ax, ay, az, bx, by, bz, cx, cy, cz};
  endfunction

  function automatic int rnd_s(int mag);
    return $signed($urandom_range(2 * mag)) - mag;
  endfunction

  // triangle built around a point on the ray, so hits are common
  function automatic in_item_t near_ray_tri();
    int p[3];
    logic signed [63:0] t0;
    t0 = $urandom_range(8 * ONE);
    for (int i = 0; i < 3; i++)
      p[i] = ray_org[i] + int'((64'(ray_dir[i]) * t0) >>> FRAC);
    return mk_tri(p[0] + rnd_s(4 * ONE), p[1] + rnd_s(4 * ONE), p[2] + rnd_s(4 * ONE),
                  p[0] + rnd_s(4 * ONE), p[1] + rnd_s(4 * ONE), p[2] + rnd_s(4 * ONE),
                  p[0] + rnd_s(4 * ONE), p[1] + rnd_s(4 * ONE), p[2] + rnd_s(4 * ONE));
  endfunction

  function automatic in_item_t any_tri();
    in_item_t t;
    for (int i = 0; i < 9; i++) t[32 * i +: 32] = $urandom();
    return t;
  endfunction

  // reset ray is all zero: every triangle misses
  task automatic test_reset_ray();
    send_tri(mk_tri(-ONE, -ONE, 5 * ONE, 3 * ONE, -ONE, 5 * ONE, -ONE, 3 * ONE, 5 * ONE));
    send_tri(any_tri());
    drain();
  endtask

  task automatic test_directed();
    write_ray(0, 0, 0, 0, 0, ONE);
    // plain hit, reversed winding
    send_tri(mk_tri(-ONE, -ONE, 5 * ONE, 3 * ONE, -ONE, 5 * ONE, -ONE, 3 * ONE, 5 * ONE));
    send_tri(mk_tri(-ONE, -ONE, 5 * ONE, -ONE, 3 * ONE, 5 * ONE, 3 * ONE, -ONE, 5 * ONE));
    // behind the origin, at the origin
    send_tri(mk_tri(-ONE, -ONE, -5 * ONE, 3 * ONE, -ONE, -5 * ONE, -ONE, 3 * ONE, -5 * ONE));
    send_tri(mk_tri(-ONE, -ONE, 0, 3 * ONE, -ONE, 0, -ONE, 3 * ONE, 0));
    // outside in u on both sides, outside in v on both sides
    send_tri(mk_tri(9 * ONE, -ONE, ONE, 13 * ONE, -ONE, ONE, 9 * ONE, 3 * ONE, ONE));
    send_tri(mk_tri(-11 * ONE, -ONE, ONE, -7 * ONE, -ONE, ONE, -11 * ONE, 3 * ONE, ONE));
    send_tri(mk_tri(-ONE, 9 * ONE, ONE, 3 * ONE, 9 * ONE, ONE, -ONE, 13 * ONE, ONE));
    send_tri(mk_tri(-ONE, -11 * ONE, ONE, 3 * ONE, -11 * ONE, ONE, -ONE, -7 * ONE, ONE));
    // beyond the long edge (u + v > 1)
    send_tri(mk_tri(-3 * ONE, -3 * ONE, ONE, -ONE, -3 * ONE, ONE, -3 * ONE, -ONE, ONE));
    // parallel to the ray, degenerate (all corners equal)
    send_tri(mk_tri(ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE));
    send_tri(mk_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    // field extremes
    send_tri(mk_tri(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX));
    send_tri(mk_tri(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN));
    send_tri(mk_tri(SMIN, SMIN, SMAX, SMAX, SMIN, SMAX, SMIN, SMAX, SMAX));
    send_tri(mk_tri(SMAX, SMAX, SMIN, SMIN, SMAX, SMIN, SMAX, SMIN, SMIN));
    send_tri(mk_tri(-1, -1, -1, 0, 0, 0, -1, 0, -1));
    drain();
    // one-LSB direction: the far triangle saturates the distance, the near one does not
    write_ray(0, 0, 0, 0, 0, 1);
    send_tri(mk_tri(-ONE, -ONE, 100 * ONE, 3 * ONE, -ONE, 100 * ONE,
                    -ONE, 3 * ONE, 100 * ONE));
    send_tri(mk_tri(-ONE, -ONE, 1, 3 * ONE, -ONE, 1, -ONE, 3 * ONE, 1));
    drain();
    // steep direction: hit point saturates
    write_ray(SMAX, SMIN, 0, SMAX, SMIN, ONE);
    send_tri(mk_tri(SMIN, SMIN, 8 * ONE, SMAX, SMIN, 8 * ONE, SMIN, SMAX, 8 * ONE));
    send_tri(mk_tri(SMIN, SMAX, 20000 * ONE, SMAX, SMAX, 20000 * ONE,
                    SMIN, SMIN, 20000 * ONE));
    drain();
    write_ray(SMIN, SMAX, SMIN, SMIN, SMAX, SMIN);
    send_tri(any_tri());
    send_tri(near_ray_tri());
    drain();
  endtask

  // one random phase under a given flow-control mix
  task automatic test_random(int snd_pct, int rcv_pct, int count);
    int pick;
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    write_ray(rnd_s(8 * ONE), rnd_s(8 * ONE), rnd_s(8 * ONE),
              rnd_s(2 * ONE), rnd_s(2 * ONE), rnd_s(2 * ONE));
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 70) send_tri(near_ray_tri());
      else if (pick < 85) send_tri(any_tri());
      else send_tri(mk_tri(rnd_s(8 * ONE), rnd_s(8 * ONE), rnd_s(8 * ONE),
                           rnd_s(8 * ONE), rnd_s(8 * ONE), rnd_s(8 * ONE),
                           rnd_s(8 * ONE), rnd_s(8 * ONE), rnd_s(8 * ONE)));
    end
    drain();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end
      for (int n = 0; n < 120; n++) send_tri(near_ray_tri());
    join
    drain();
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0; hold_rx = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    errors = 0; n_sent = 0; n_checked = 0; n_hits = 0; idle_gap = 0;
    snd_idle_pct = 0; rcv_stall_pct = 0;
    for (int i = 0; i < 3; i++) begin
      ray_org[i] = '0;
      ray_dir[i] = '0;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_ray();
    test_directed();
    test_random(0, 0, 500);
    test_random(65, 0, 500);
    test_random(0, 65, 500);
    test_random(13, 13, 500);
    test_backpressure();

    if (pending_hits.size() != 0) begin
      $display("%0d expected items never arrived", pending_hits.size());
      errors++;
    end
    $display("Checked %0d of %0d triangles (%0d hits) over several rays,", n_checked,
             n_sent, n_hits);
    $display("with idle and stall mixes and a long output hold-off; %0d errors.", errors);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/rti_pkg.sv
hdl/rti_div.sv
hdl/ray_triangle_intersection.sv
tb/sv/testbench.sv
